// File: rtl/lcw_stream_decompressor_assert.svh
// Assertion macros for the LCW stream decompressor.
`ifndef LCW_STREAM_DECOMPRESSOR_ASSERT_SVH
`define LCW_STREAM_DECOMPRESSOR_ASSERT_SVH
`ifndef SYNTHESIS
`define LCW_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define LCW_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define LCW_ASSERT_IMP(label, clk, rst_n, pre, post)
`define LCW_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif
`endif

// File: rtl/lcw_pkg.sv
// Shared types and constants for the LCW stream decompressor.
package lcw_pkg;

    localparam int HIST_AW = 16;

    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_TICK    = 2'd1,
        KIND_RESTART = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_BYTE   = 3'd0,
        ST_END    = 3'd1,
        ST_LIMIT  = 3'd2,
        ST_BADREF = 3'd3,
        ST_OVER   = 3'd4,
        ST_BUSY   = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        PH_CMD      = 4'd0,
        PH_SHORT2   = 4'd1,
        PH_LIT      = 4'd2,
        PH_FILL_CL  = 4'd3,
        PH_FILL_CH  = 4'd4,
        PH_FILL_V   = 4'd5,
        PH_FILL_RUN = 4'd6,
        PH_LONG_CL  = 4'd7,
        PH_LONG_CH  = 4'd8,
        PH_SRC_L    = 4'd9,
        PH_SRC_H    = 4'd10,
        PH_COPY_RUN = 4'd11,
        PH_DONE     = 4'd12
    } phase_t;

    // Back-end operation handed across the queue
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,  // write value to history and emit
        OP_COPY  = 2'd1,  // read history at source, write and emit
        OP_STAT  = 2'd2   // emit a status only
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [7:0]          value;
        logic [HIST_AW-1:0]  addr;
        logic [HIST_AW-1:0]  src;
        logic [16:0]         length;
        status_t             status;
    } job_t;

endpackage

// File: rtl/lcw_front.sv
// Command parser: decodes compressed bytes and ticks into back-end jobs.
module lcw_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           reverse_mode,
    input  logic [16:0]    output_limit,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [1:0]     kind,
    input  logic [7:0]     byte_in,
    output logic           job_valid,
    input  logic           job_ready,
    output lcw_pkg::job_t  job
);
    import lcw_pkg::*;
    `include "lcw_stream_decompressor_assert.svh"

    phase_t      phase_reg, phase_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [15:0] run_reg, run_next;
    logic [15:0] src_reg, src_next;
    logic [16:0] idx_reg, idx_next;
    logic [7:0]  wlo_reg, wlo_next;
    logic [7:0]  fill_reg, fill_next;

    logic        fire;
    logic [16:0] limit;
    logic [17:0] end_pos;
    logic [15:0] word;
    logic        rel;
    logic [16:0] src_calc;
    logic        bad_ref;
    logic [15:0] short_run;

    assign in_ready = job_ready;
    assign fire     = in_valid && in_ready;
    assign limit    = (output_limit > 17'h10000) ? 17'h10000 : output_limit;

    always_comb
    begin
        // source word and mode for copies resolved on this byte
        if (phase_reg == PH_SHORT2)
        begin
            word = {4'd0, cmd_reg[3:0], byte_in};
            rel  = 1'b1;
        end
        else
        begin
            word = {byte_in, wlo_reg};
            rel  = reverse_mode;
        end
        short_run = {13'd0, cmd_reg[6:4]} + 16'd3;
        if (rel)
            src_calc = idx_reg - {1'b0, word};
        else
            src_calc = {1'b0, word};
        if (rel)
            bad_ref = ({1'b0, word} > idx_reg) || (word == 16'd0);
        else
            bad_ref = (src_calc >= idx_reg);
        // distance never exceeds 65536 since idx <= 65536
    end

    always_comb
    begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        run_next   = run_reg;
        src_next   = src_reg;
        idx_next   = idx_reg;
        wlo_next   = wlo_reg;
        fill_next  = fill_reg;
        job_valid  = 1'b0;
        job        = '0;
        job.op     = OP_STAT;
        job.status = ST_BYTE;
        end_pos    = {1'b0, idx_reg} + {2'd0, run_reg};
        if (fire)
        begin
            case (kind_t'(kind))
                KIND_RESTART:
                begin
                    phase_next = PH_CMD;
                    cmd_next = '0; run_next = '0; src_next = '0;
                    idx_next = '0; wlo_next = '0; fill_next = '0;
                end
                KIND_TICK:
                begin
                    if (phase_reg == PH_FILL_RUN || phase_reg == PH_COPY_RUN)
                    begin
                        job_valid = 1'b1;
                        job.op    = (phase_reg == PH_FILL_RUN) ? OP_WRITE : OP_COPY;
                        job.value = fill_reg;
                        job.addr  = idx_reg[HIST_AW-1:0];
                        job.src   = src_reg[HIST_AW-1:0];
                        if (phase_reg == PH_COPY_RUN)
                            src_next = src_reg + 16'd1;
                        run_next = run_reg - 16'd1;
                        if (run_reg == 16'd1)
                            phase_next = PH_CMD;
                        idx_next = idx_reg + 17'd1;
                    end
                end
                KIND_BYTE:
                begin
                    case (phase_reg)
                        PH_CMD:
                        begin
                            cmd_next = byte_in;
                            if (!byte_in[7])
                                phase_next = PH_SHORT2;
                            else if (!byte_in[6])
                            begin
                                run_next = {10'd0, byte_in[5:0]};
                                end_pos = {1'b0, idx_reg} + {12'd0, byte_in[5:0]};
                                if (byte_in[5:0] == 6'd0)
                                begin
                                    job_valid = 1'b1; job.status = ST_END;
                                    job.length = idx_reg; phase_next = PH_DONE;
                                end
                                else if (end_pos > {1'b0, limit})
                                begin
                                    job_valid = 1'b1; job.status = ST_OVER;
                                    job.length = idx_reg; phase_next = PH_DONE;
                                end
                                else
                                    phase_next = PH_LIT;
                            end
                            else if (byte_in[5:0] == 6'h3E)
                                phase_next = PH_FILL_CL;
                            else if (byte_in[5:0] == 6'h3F)
                                phase_next = PH_LONG_CL;
                            else
                            begin
                                run_next = {10'd0, byte_in[5:0]} + 16'd3;
                                phase_next = PH_SRC_L;
                            end
                        end
                        PH_SHORT2, PH_SRC_H:
                        begin
                            if (phase_reg == PH_SHORT2)
                            begin
                                run_next = short_run;
                                end_pos = {1'b0, idx_reg} + {2'd0, short_run};
                            end
                            if (phase_reg == PH_SHORT2 && end_pos > {1'b0, limit})
                            begin
                                job_valid = 1'b1; job.status = ST_LIMIT;
                                job.length = idx_reg; phase_next = PH_DONE;
                            end
                            else if (bad_ref)
                            begin
                                job_valid = 1'b1; job.status = ST_BADREF;
                                job.length = idx_reg; phase_next = PH_DONE;
                            end
                            else
                            begin
                                src_next = src_calc[15:0];
                                if (end_pos > {1'b0, limit})
                                begin
                                    job_valid = 1'b1; job.status = ST_OVER;
                                    job.length = idx_reg; phase_next = PH_DONE;
                                end
                                else if (phase_reg == PH_SHORT2 || run_reg != 16'd0)
                                    phase_next = PH_COPY_RUN;
                                else
                                    phase_next = PH_CMD;
                            end
                        end
                        PH_LIT:
                        begin
                            job_valid = 1'b1;
                            job.op    = OP_WRITE;
                            job.value = byte_in;
                            job.addr  = idx_reg[HIST_AW-1:0];
                            run_next  = run_reg - 16'd1;
                            if (run_reg == 16'd1)
                                phase_next = PH_CMD;
                            idx_next = idx_reg + 17'd1;
                        end
                        PH_FILL_CL, PH_LONG_CL, PH_SRC_L:
                        begin
                            wlo_next = byte_in;
                            phase_next = phase_t'(phase_reg + 4'd1);
                        end
                        PH_FILL_CH, PH_LONG_CH:
                        begin
                            run_next = {byte_in, wlo_reg};
                            phase_next = (phase_reg == PH_FILL_CH) ? PH_FILL_V : PH_SRC_L;
                        end
                        PH_FILL_V:
                        begin
                            fill_next = byte_in;
                            if (end_pos > {1'b0, limit})
                            begin
                                job_valid = 1'b1; job.status = ST_OVER;
                                job.length = idx_reg; phase_next = PH_DONE;
                            end
                            else
                                phase_next = (run_reg != 16'd0) ? PH_FILL_RUN : PH_CMD;
                        end
                        PH_FILL_RUN, PH_COPY_RUN:
                        begin
                            job_valid = 1'b1; job.status = ST_BUSY;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_CMD;
            cmd_reg   <= '0;
            run_reg   <= '0;
            src_reg   <= '0;
            idx_reg   <= '0;
            wlo_reg   <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            run_reg   <= run_next;
            src_reg   <= src_next;
            idx_reg   <= idx_next;
            wlo_reg   <= wlo_next;
            fill_reg  <= fill_next;
        end
    end

    `LCW_ASSERT_IMP(a_job_needs_fire, clk, rst_n, job_valid, fire)
    `LCW_ASSERT_NXT(a_done_sticks, clk, rst_n,
        phase_reg == PH_DONE && !(fire && kind == KIND_RESTART), phase_reg == PH_DONE)
    `LCW_ASSERT_IMP(a_idx_bound, clk, rst_n, 1'b1, idx_reg <= 17'h10000)
endmodule

// File: rtl/lcw_back.sv
// Executor: history store, job queue and output register.
module lcw_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    output logic           job_ready,
    input  lcw_pkg::job_t  job,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     data,
    output logic [15:0]    position,
    output logic [16:0]    length,
    output logic [2:0]     status
);
    import lcw_pkg::*;
    `include "lcw_stream_decompressor_assert.svh"

    localparam int HistDepth = 1 << HIST_AW;

    logic [7:0] hist [HistDepth];

    // Stage 1 holds a job while its history read is in flight.
    logic        s1_valid_reg;
    job_t        s1_reg;
    logic [7:0]  rd_reg;
    // Two-entry output queue; read-after-write bypass for one-byte distance.
    logic [1:0]  cnt_reg;
    logic        rp_reg, wp_reg;
    logic [7:0]  q_data [2];
    logic [15:0] q_pos  [2];
    logic [16:0] q_len  [2];
    logic [2:0]  q_st   [2];
    logic        s1_adv, push, pop;
    logic [7:0]  s1_byte;
    logic        fwd_reg;
    logic [7:0]  last_reg;

    // Room check: a job in stage 1 plus entries must fit the queue.
    assign pop       = out_valid && out_ready;
    assign job_ready = ({1'b0, cnt_reg} + {2'd0, s1_valid_reg}) < 3'd2 || pop;
    assign s1_adv    = s1_valid_reg;
    assign push      = s1_adv;

    always_comb
    begin
        if (s1_reg.op == OP_COPY)
            s1_byte = fwd_reg ? last_reg : rd_reg;
        else
            s1_byte = s1_reg.value;
    end

    always_ff @(posedge clk)
    begin
        if (job_valid && job_ready)
            rd_reg <= hist[job.src];
        if (push && s1_reg.op != OP_STAT)
            hist[s1_reg.addr] <= s1_byte;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            last_reg <= s1_byte;
            q_data[wp_reg] <= (s1_reg.op == OP_STAT) ? 8'd0 : s1_byte;
            q_pos[wp_reg]  <= (s1_reg.op == OP_STAT) ? 16'd0 : s1_reg.addr;
            q_len[wp_reg]  <= s1_reg.length;
            q_st[wp_reg]   <= (s1_reg.op == OP_STAT) ? s1_reg.status : ST_BYTE;
        end
        if (job_valid && job_ready)
        begin
            s1_reg  <= job;
            fwd_reg <= push && s1_reg.op != OP_STAT && s1_reg.addr == job.src;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            cnt_reg <= '0;
            rp_reg  <= 1'b0;
            wp_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= job_valid && job_ready;
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assign out_valid = cnt_reg != 2'd0;
    assign data      = q_data[rp_reg];
    assign position  = q_pos[rp_reg];
    assign length    = q_len[rp_reg];
    assign status    = q_st[rp_reg];

    `LCW_ASSERT_IMP(a_no_overflow, clk, rst_n, 1'b1, cnt_reg <= 2'd2)
    `LCW_ASSERT_IMP(a_push_room, clk, rst_n, push && !pop, cnt_reg != 2'd2)
    `LCW_ASSERT_NXT(a_stage_drains, clk, rst_n, s1_valid_reg && !(job_valid && job_ready),
        !s1_valid_reg)
endmodule

// File: rtl/lcw_stream_decompressor.sv
// Top level of the LCW stream decompressor.
// A result is registered in the read stage and then in the output queue before it is valid.
// Throughput: one request per cycle when not stalled; each tick of a copy reads the history RAM once.
// Requests stall when the read stage and the two-entry output queue hold two results
// and none leaves in that cycle.
// Reset (rst_n, async low) clears parse state, registers and queue; history is not cleared.
module lcw_stream_decompressor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [7:0] data, [23:8] position, [40:24] length
    output logic [2:0]  m_axis_tuser,   // [2:0] status
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [16:0] cfg_data
);
    import lcw_pkg::*;

    logic        reverse_reg;
    logic [16:0] limit_reg;
    logic        job_valid, job_ready;
    job_t        job;
    logic [7:0]  data;
    logic [15:0] position;
    logic [16:0] length;
    logic [2:0]  status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reverse_reg <= 1'b0;
            limit_reg   <= 17'h10000;
        end
        else if (cfg_we)
        begin
            if (cfg_index == 1'b0)
                reverse_reg <= cfg_data[0];
            else
                limit_reg <= cfg_data;
        end
    end

    lcw_front u_front (
        .clk, .rst_n,
        .reverse_mode (reverse_reg),
        .output_limit (limit_reg),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .kind         (s_axis_tuser),
        .byte_in      (s_axis_tdata),
        .job_valid, .job_ready, .job
    );

    lcw_back u_back (
        .clk, .rst_n,
        .job_valid, .job_ready, .job,
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .data, .position, .length, .status
    );

    assign m_axis_tdata = {7'd0, length, position, data};
    assign m_axis_tuser = status;
endmodule

// File: tb/tb_lcw_stream_decompressor.sv
// Testbench for the LCW stream decompressor: random and directed streams, checked by prediction.
`timescale 1ns / 1ps

module tb_lcw_stream_decompressor;
    import lcw_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic [1:0]  s_axis_tuser = 2'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [16:0] cfg_data = 17'd0;

    lcw_stream_decompressor uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    typedef struct packed {
        logic [7:0]  data;
        logic [15:0] position;
        logic [16:0] length;
        status_t     status;
    } decoded_t;

    // pending requests: {kind, byte}
    logic [9:0]  request_q[$];
    decoded_t    decoded_q[$];

    // decoder shadow state
    logic        dec_reverse = 1'b0;
    logic [16:0] dec_limit = 17'h10000;
    phase_t      dec_phase = PH_CMD;
    logic [7:0]  dec_cmd = 8'd0;
    logic [16:0] dec_run = 17'd0;
    logic [16:0] dec_src = 17'd0;
    logic [16:0] dec_out = 17'd0;
    logic [7:0]  dec_wlow = 8'd0;
    logic [7:0]  dec_fill = 8'd0;
    logic [7:0]  dec_hist [65536];

    int errors = 0;
    int cycles = 0;
    int n_requests = 0;
    int n_results = 0;
    int n_streams = 0;
    int n_settings = 0;
    int gen_out = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int recv_hold = 0;
    bit hold_done = 0;
    bit took = 0;

    function automatic int lim_eff();
        return (dec_limit > 17'h10000) ? 32'h10000 : int'(dec_limit);
    endfunction

    function automatic decoded_t mk(logic [7:0] d, logic [15:0] p, logic [16:0] l,
                                    status_t s);
        decoded_t r;
        r.data = d; r.position = p; r.length = l; r.status = s;
        return r;
    endfunction

    function automatic decoded_t end_stream(status_t s);
        dec_phase = PH_DONE;
        return mk(8'd0, 16'd0, dec_out, s);
    endfunction

    function automatic decoded_t put_byte(logic [7:0] v);
        decoded_t r;
        dec_hist[dec_out[15:0]] = v;
        r = mk(v, dec_out[15:0], 17'd0, ST_BYTE);
        dec_out = dec_out + 1;
        return r;
    endfunction

    // returns 1 with r set when a result is expected
    function automatic bit begin_copy(int word, bit rel, output decoded_t r);
        int src;
        int outi;
        outi = int'(dec_out);
        if (rel) src = (word > outi) ? -1 : outi - word;
        else src = word;
        if (src < 0 || src >= outi || outi - src > 65536) begin
            r = end_stream(ST_BADREF);
            return 1;
        end
        dec_src = src;
        if (outi + int'(dec_run) > lim_eff()) begin
            r = end_stream(ST_OVER);
            return 1;
        end
        dec_phase = (dec_run != 0) ? PH_COPY_RUN : PH_CMD;
        return 0;
    endfunction

    function automatic bit decode_step(logic [1:0] kind, logic [7:0] b, output decoded_t r);
        logic [7:0] v;
        r = '0;
        if (kind == KIND_RESTART) begin
            dec_phase = PH_CMD; dec_cmd = 0; dec_run = 0; dec_src = 0;
            dec_out = 0; dec_wlow = 0; dec_fill = 0;
            return 0;
        end
        if (kind == KIND_TICK) begin
            if (dec_phase == PH_FILL_RUN) v = dec_fill;
            else if (dec_phase == PH_COPY_RUN) begin
                v = dec_hist[dec_src[15:0]];
                dec_src = dec_src + 1;
            end else return 0;
            dec_run = dec_run - 1;
            if (dec_run == 0) dec_phase = PH_CMD;
            r = put_byte(v);
            return 1;
        end
        if (kind != KIND_BYTE) return 0;
        case (dec_phase)
            PH_CMD: begin
                dec_cmd = b;
                if (!b[7]) dec_phase = PH_SHORT2;
                else if (!b[6]) begin
                    dec_run = b[5:0];
                    if (dec_run == 0) begin
                        r = end_stream(ST_END);
                        return 1;
                    end
                    if (int'(dec_out) + int'(dec_run) > lim_eff()) begin
                        r = end_stream(ST_OVER);
                        return 1;
                    end
                    dec_phase = PH_LIT;
                end
                else if (b[5:0] == 6'h3E) dec_phase = PH_FILL_CL;
                else if (b[5:0] == 6'h3F) dec_phase = PH_LONG_CL;
                else begin
                    dec_run = b[5:0] + 3;
                    dec_phase = PH_SRC_L;
                end
                return 0;
            end
            PH_SHORT2: begin
                dec_run = dec_cmd[6:4] + 3;
                if (int'(dec_out) + int'(dec_run) > lim_eff()) begin
                    r = end_stream(ST_LIMIT);
                    return 1;
                end
                return begin_copy({dec_cmd[3:0], b}, 1'b1, r);
            end
            PH_LIT: begin
                dec_run = dec_run - 1;
                if (dec_run == 0) dec_phase = PH_CMD;
                r = put_byte(b);
                return 1;
            end
            PH_FILL_CL, PH_LONG_CL, PH_SRC_L: begin
                dec_wlow = b;
                dec_phase = phase_t'(dec_phase + 1);
                return 0;
            end
            PH_FILL_CH, PH_LONG_CH: begin
                dec_run = {b, dec_wlow};
                dec_phase = (dec_phase == PH_FILL_CH) ? PH_FILL_V : PH_SRC_L;
                return 0;
            end
            PH_FILL_V: begin
                dec_fill = b;
                if (int'(dec_out) + int'(dec_run) > lim_eff()) begin
                    r = end_stream(ST_OVER);
                    return 1;
                end
                dec_phase = (dec_run != 0) ? PH_FILL_RUN : PH_CMD;
                return 0;
            end
            PH_SRC_H: return begin_copy({b, dec_wlow}, dec_reverse, r);
            PH_FILL_RUN, PH_COPY_RUN: begin
                r = mk(8'd0, 16'd0, 17'd0, ST_BUSY);
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    task automatic push_req(logic [1:0] kind, logic [7:0] b);
        request_q.push_back({kind, b});
        n_requests++;
    endtask

    task automatic push_ticks(int n);
        for (int i = 0; i < n; i++) begin
            // occasional stray byte mid-run, rejected as busy
            if ($urandom_range(0, 40) == 0) push_req(KIND_BYTE, 8'($urandom));
            push_req(KIND_TICK, 8'($urandom));
        end
    endtask

    task automatic push_word(int w);
        push_req(KIND_BYTE, w[7:0]);
        push_req(KIND_BYTE, w[15:8]);
    endtask

    function automatic int small_count();
        if ($urandom_range(0, 30) == 0) return $urandom_range(0, 300);
        return $urandom_range(0, 12);
    endfunction

    // one stream of mostly well-formed commands with random content
    task automatic gen_stream(int ncmd, bit rev);
        int n, d, sel;
        push_req(KIND_RESTART, 8'($urandom));
        gen_out = 0;
        n_streams++;
        for (int c = 0; c < ncmd; c++) begin
            sel = (gen_out == 0) ? $urandom_range(0, 1) : $urandom_range(0, 9);
            case (sel)
                0, 2: begin
                    n = $urandom_range(1, 8);
                    push_req(KIND_BYTE, 8'h80 | n[7:0]);
                    for (int i = 0; i < n; i++) push_req(KIND_BYTE, 8'($urandom));
                    gen_out += n;
                end
                1: begin
                    n = small_count();
                    push_req(KIND_BYTE, 8'hFE);
                    push_word(n);
                    push_req(KIND_BYTE, 8'($urandom));
                    push_ticks(n);
                    gen_out += n;
                end
                3, 4: begin
                    n = $urandom_range(3, 10);
                    d = $urandom_range(1, (gen_out > 4095) ? 4095 : gen_out);
                    push_req(KIND_BYTE, {1'b0, 3'(n - 3), 4'(d >> 8)});
                    push_req(KIND_BYTE, d[7:0]);
                    push_ticks(n);
                    gen_out += n;
                end
                5, 6, 7: begin
                    if (sel == 7) begin
                        n = small_count();
                        push_req(KIND_BYTE, 8'hFF);
                        push_word(n);
                    end else begin
                        n = $urandom_range(3, 64);
                        push_req(KIND_BYTE, 8'hC0 | 8'(n - 3));
                    end
                    d = $urandom_range(1, gen_out);
                    if ($urandom_range(0, 15) == 0) push_word($urandom);
                    else push_word(rev ? d : gen_out - d);
                    push_ticks(n);
                    gen_out += n;
                end
                8: push_req(KIND_TICK, 8'($urandom));
                default: begin
                    // noise
                    if ($urandom_range(0, 3) == 0) push_req(KIND_NONE, 8'($urandom));
                    else push_req(KIND_BYTE, 8'($urandom));
                end
            endcase
        end
        if ($urandom_range(0, 5) != 0) push_req(KIND_BYTE, 8'h80);
        if ($urandom_range(0, 3) == 0) push_req(KIND_TICK, 8'($urandom));
    endtask

    task automatic settle();
        wait (request_q.size() == 0 && !s_axis_tvalid);
        wait (decoded_q.size() == 0);
        repeat (12) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [16:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        if (idx) dec_limit = val;
        else dec_reverse = val[0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_mode(logic rev, logic [16:0] lim);
        settle();
        write_reg(1'b0, {16'd0, rev});
        write_reg(1'b1, lim);
        n_settings++;
    endtask

    initial begin
        forever #1 clk = ~clk;
    end

    // request side: acceptance and prediction, then result check
    always @(posedge clk) begin
        decoded_t exp_r, got;
        cycles++;
        if (rst_n && s_axis_tvalid && s_axis_tready) begin
            took = 1;
            if (decode_step(s_axis_tuser, s_axis_tdata, exp_r)) decoded_q.push_back(exp_r);
        end
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got.data     = m_axis_tdata[7:0];
            got.position = m_axis_tdata[23:8];
            got.length   = m_axis_tdata[40:24];
            got.status   = status_t'(m_axis_tuser);
            n_results++;
            if (decoded_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
            end else begin
                exp_r = decoded_q.pop_front();
                if (got.data !== exp_r.data)
                    $display("%0t: data expected %h actual %h", $time, exp_r.data, got.data);
                if (got.position !== exp_r.position)
                    $display("%0t: position expected %h actual %h", $time,
                             exp_r.position, got.position);
                if (got.length !== exp_r.length)
                    $display("%0t: length expected %h actual %h", $time,
                             exp_r.length, got.length);
                if (got.status !== exp_r.status)
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_r.status, got.status);
                if (got !== exp_r) errors++;
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // driver
    always @(negedge clk) begin
        if (rst_n && (!s_axis_tvalid || took)) begin
            if (send_gap > 0 || request_q.size() == 0) begin
                if (send_gap > 0) send_gap--;
                s_axis_tvalid <= 1'b0;
            end else begin
                {s_axis_tuser, s_axis_tdata} <= request_q.pop_front();
                s_axis_tvalid <= 1'b1;
                case ($urandom_range(0, 9))
                    0, 1: send_gap = $urandom_range(1, 3);
                    2:    send_gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : 0;
                    default: send_gap = 0;
                endcase
            end
        end
        took = 0;
    end

    // receiver, with one long hold-off to back the block up
    always @(negedge clk) begin
        if (!hold_done && n_results == 150) begin
            hold_done <= 1;
            recv_hold = 300;
        end
        if (recv_hold > 0) begin
            recv_hold--;
            m_axis_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            case ($urandom_range(0, 11))
                0, 1: recv_gap = $urandom_range(1, 3);
                2:    recv_gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : 0;
                default: recv_gap = 0;
            endcase
        end
    end

    initial begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: literals, fill, short/medium/long copies, end marker
        push_req(KIND_BYTE, 8'h82); push_req(KIND_BYTE, 8'h00); push_req(KIND_BYTE, 8'hFF);
        push_req(KIND_TICK, 8'h00);                       // idle tick
        push_req(KIND_BYTE, 8'hFE); push_word(3); push_req(KIND_BYTE, 8'hA5);
        push_req(KIND_BYTE, 8'h11);                       // busy reject
        push_ticks(3);
        push_req(KIND_BYTE, 8'h70); push_req(KIND_BYTE, 8'h01); push_ticks(10);
        push_req(KIND_BYTE, 8'hC0); push_word(0); push_ticks(3);
        push_req(KIND_BYTE, 8'hFF); push_word(0); push_word(1);   // zero-count long copy
        push_req(KIND_BYTE, 8'hFE); push_word(0); push_req(KIND_BYTE, 8'h5A);
        push_req(KIND_NONE, 8'hFF);
        push_req(KIND_BYTE, 8'h00); push_req(KIND_BYTE, 8'h00);   // zero distance
        push_req(KIND_BYTE, 8'h81); push_req(KIND_TICK, 8'h00);   // ignored after end
        push_req(KIND_RESTART, 8'h00);
        push_req(KIND_BYTE, 8'h81); push_req(KIND_BYTE, 8'h7E);
        push_req(KIND_BYTE, 8'hC0); push_word(5);                 // source ahead of output
        push_req(KIND_RESTART, 8'h00);
        push_req(KIND_BYTE, 8'h80);

        for (int s = 0; s < 4; s++) gen_stream($urandom_range(4, 20), 1'b0);
        set_mode(1'b1, 17'h10000);
        for (int s = 0; s < 4; s++) gen_stream($urandom_range(4, 20), 1'b1);
        set_mode(1'b0, 17'd40);
        for (int s = 0; s < 4; s++) gen_stream($urandom_range(4, 14), 1'b0);
        set_mode(1'b1, 17'd1);
        for (int s = 0; s < 3; s++) gen_stream($urandom_range(2, 6), 1'b1);
        set_mode(1'b0, 17'd0);
        for (int s = 0; s < 2; s++) gen_stream($urandom_range(2, 6), 1'b0);
        set_mode(1'b1, 17'h1FFFF);
        while (n_requests < 1450) gen_stream($urandom_range(4, 20), 1'b1);
        set_mode(1'b0, 17'd1000);
        while (n_requests < 1650) gen_stream($urandom_range(4, 20), 1'b0);

        settle();
        repeat (20) @(negedge clk);
        $display("Ran %0d requests over %0d streams and %0d register settings,",
                 n_requests, n_streams, n_settings);
        $display("checked %0d results, with a long output stall.", n_results);
        if (errors == 0 && decoded_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/lcw_pkg.sv
rtl/lcw_front.sv
rtl/lcw_back.sv
rtl/lcw_stream_decompressor.sv
tb/tb_lcw_stream_decompressor.sv
